### design/srfg_pkg.sv
// ============================================================================
// srfg_pkg: shared definitions of the stall ratio frequency governor
// Widths, register indexes, reset values, outcome codes, divider handshake
// types and the sequencer state type used across the governor's modules.
// ============================================================================
package srfg_pkg;

    localparam int FREQ_W     = 24;
    localparam int DELAY_W    = 32;
    localparam int PCT_REG_W  = 7;
    localparam int CNT_W      = 64;
    localparam int TIME_W     = 64;
    localparam int OUTCOME_W  = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PCT_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PCT_LOW      = 3'd4;

    localparam logic [FREQ_W-1:0]    RST_FREQ_MAX     = 24'd3000000;
    localparam logic [FREQ_W-1:0]    RST_FREQ_MIN     = 24'd800000;
    localparam logic [DELAY_W-1:0]   RST_UPDATE_DELAY = 32'd5000000;
    localparam logic [PCT_REG_W-1:0] RST_PCT_HIGH     = 7'd65;
    localparam logic [PCT_REG_W-1:0] RST_PCT_LOW      = 7'd10;

    localparam logic [OUTCOME_W-1:0] OUTCOME_COMPUTED = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_KEPT     = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FAILED   = 2'd2;

    // Shared bit-serial divider: numerator wide enough for 100 times a delta.
    localparam int DIV_NUM_W = CNT_W + 7;
    localparam int DIV_DEN_W = CNT_W;
    localparam int DIV_QUO_W = FREQ_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Significant numerator bits of the factor and frequency divisions.
    localparam int FAC_NUM_W = 15;
    localparam int FRQ_NUM_W = FREQ_W + 7;

    localparam int              PCT_W    = 9;
    localparam logic [PCT_W-1:0] PCT_CAP = 9'd300;
    localparam logic [6:0]      FAC_FULL = 7'd100;
    localparam int              FRQ_DIVISOR = 100;

    typedef struct packed {
        logic [FREQ_W-1:0]    freq_max;
        logic [FREQ_W-1:0]    freq_min;
        logic [DELAY_W-1:0]   update_delay;
        logic [PCT_REG_W-1:0] pct_high;
        logic [PCT_REG_W-1:0] pct_low;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_PCT_MUL,
        S_PCT_LOAD,
        S_PCT_DIV,
        S_FAC_LOAD,
        S_FAC_DIV,
        S_FRQ_MUL,
        S_FRQ_LOAD,
        S_FRQ_DIV,
        S_EMIT
    } state_t;

endpackage

### design/srfg_cfg.sv
// ============================================================================
// srfg_cfg: configuration register bank
// Holds the frequency limits, update delay and stall bounds, written by index.
// ============================================================================
module srfg_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [srfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srfg_pkg::CFG_DATA_W-1:0] cfg_data,
    output srfg_pkg::cfg_t                cfg
);
    import srfg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FREQ_MAX:     cfg_next.freq_max     = cfg_data[FREQ_W-1:0];
                CFG_FREQ_MIN:     cfg_next.freq_min     = cfg_data[FREQ_W-1:0];
                CFG_UPDATE_DELAY: cfg_next.update_delay = cfg_data[DELAY_W-1:0];
                CFG_PCT_HIGH:     cfg_next.pct_high     = cfg_data[PCT_REG_W-1:0];
                CFG_PCT_LOW:      cfg_next.pct_low      = cfg_data[PCT_REG_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freq_max     <= RST_FREQ_MAX;
            cfg_reg.freq_min     <= RST_FREQ_MIN;
            cfg_reg.update_delay <= RST_UPDATE_DELAY;
            cfg_reg.pct_high     <= RST_PCT_HIGH;
            cfg_reg.pct_low      <= RST_PCT_LOW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/srfg_div.sv
// ============================================================================
// srfg_div: shared bit-serial restoring divider
// Takes one numerator bit per cycle, MSB first, and builds the quotient in a
// shift register; quotient bits that fall off the top set a sticky overflow.
// ============================================================================
module srfg_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  srfg_pkg::div_req_t             req,
    input  logic [srfg_pkg::DIV_NUM_W-1:0] num,
    input  logic [srfg_pkg::DIV_DEN_W-1:0] den,
    output srfg_pkg::div_rsp_t             rsp,
    output logic [srfg_pkg::DIV_QUO_W-1:0] quo
);
    import srfg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_sh_reg, num_sh_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_QUO_W-1:0] quo_reg, quo_next;
    logic                 ovf_reg, ovf_next;

    logic [DIV_DEN_W:0]   rem_shift;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;

    assign rem_shift = {rem_reg, num_sh_reg[DIV_NUM_W-1]};
    assign ge        = (rem_shift >= {1'b0, den_reg});
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign quo      = quo_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        num_sh_next = num_sh_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        ovf_next    = ovf_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            cnt_next    = req.nbits;
            num_sh_next = num;
            rem_next    = '0;
            den_next    = den;
            quo_next    = '0;
            ovf_next    = 1'b0;
        end
        else if (busy_reg)
        begin
            num_sh_next = {num_sh_reg[DIV_NUM_W-2:0], 1'b0};
            rem_next    = ge ? rem_sub[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
            quo_next    = {quo_reg[DIV_QUO_W-2:0], ge};
            ovf_next    = ovf_reg | quo_reg[DIV_QUO_W-1];
            cnt_next    = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_sh_reg <= num_sh_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        ovf_reg    <= ovf_next;
    end

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while still busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("divider done without a preceding busy run");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with an exhausted bit count");

endmodule

### design/stall_ratio_frequency_governor_core.sv
// ============================================================================
// stall_ratio_frequency_governor_core: stall ratio frequency governor
// Turns per-tick cycle and stall counter readings into a requested core
// frequency, using one shared bit-serial divider for all three divisions.
// ============================================================================
//
//  Channel | Handshake              | Word
//  --------+------------------------+------------------------------------------
//  tick    | tick_valid / tick_stall| time_ns, on_own_cpu, cycles_ok,
//          |                        | cycles_total, stalls_ok, stalls_total
//  result  | result_valid /         | requested_freq_khz, outcome,
//          | result_stall           | cycle_delta, stall_delta
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A tick word that is ignored (remote core or too early) frees the input after
// the check state; a read failure or a zero cycle delta goes from the check
// state to the emit state. A computed decision waits on the shared divider,
// which runs 71 bit steps for the stall percentage, 15 for the interpolation
// factor (skipped with equal stall bounds) and 31 for the frequency scaling,
// each ending with a registered done flag. Reset clears the baselines and the
// last update time and sets the last frequency to the reset maximum. The result
// sits in an output register, so a stalled result word does not hold back the
// next tick; only a second result has to wait for the first to be taken.
//
module stall_ratio_frequency_governor_core (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             tick_valid,
    output logic                             tick_stall,
    input  logic [srfg_pkg::TIME_W-1:0]      time_ns,
    input  logic                             on_own_cpu,
    input  logic                             cycles_ok,
    input  logic [srfg_pkg::CNT_W-1:0]       cycles_total,
    input  logic                             stalls_ok,
    input  logic [srfg_pkg::CNT_W-1:0]       stalls_total,

    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [srfg_pkg::FREQ_W-1:0]      requested_freq_khz,
    output logic [srfg_pkg::OUTCOME_W-1:0]   outcome,
    output logic [srfg_pkg::CNT_W-1:0]       cycle_delta,
    output logic [srfg_pkg::CNT_W-1:0]       stall_delta,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srfg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srfg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import srfg_pkg::*;

    cfg_t cfg;

    // Sequencer state and architectural state of the governor.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cycle_baseline_reg, cycle_baseline_next;
    logic [CNT_W-1:0]   stall_baseline_reg, stall_baseline_next;
    logic [TIME_W-1:0]  last_update_time_reg, last_update_time_next;
    logic [FREQ_W-1:0]  prev_freq_reg, prev_freq_next;
    logic               result_valid_reg, result_valid_next;

    // Captured tick word.
    logic [TIME_W-1:0]  time_reg;
    logic               own_reg, cyc_ok_reg, stl_ok_reg;
    logic [CNT_W-1:0]   cyc_in_reg, stl_in_reg;

    // Working registers of one decision.
    logic [CNT_W-1:0]     cd_reg, cd_next;
    logic [CNT_W-1:0]     sd_reg, sd_next;
    logic [DIV_NUM_W-1:0] work_reg, work_next;
    logic [PCT_W-1:0]     pct_reg, pct_next;
    logic [6:0]           fac_reg, fac_next;
    logic                 neg_reg, neg_next;
    logic [FRQ_NUM_W-1:0] prod_reg, prod_next;
    logic [FREQ_W-1:0]    freq_reg, freq_next;
    logic [OUTCOME_W-1:0] outcome_reg, outcome_next;

    // Result output register.
    logic [FREQ_W-1:0]    res_freq_reg, res_freq_next;
    logic [OUTCOME_W-1:0] res_outcome_reg, res_outcome_next;
    logic [CNT_W-1:0]     res_cd_reg, res_cd_next;
    logic [CNT_W-1:0]     res_sd_reg, res_sd_next;

    // Divider connection.
    div_req_t             div_req;
    div_rsp_t             div_rsp;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_QUO_W-1:0] div_quo;

    // Intermediate values.
    logic                  tick_accept;
    logic [TIME_W-1:0]     elapsed;
    logic                  too_early;
    logic [CNT_W-1:0]      cyc_diff, stl_diff;
    logic [PCT_W-1:0]      pct_sat;
    logic signed [9:0]     pct_diff;
    logic signed [16:0]    fac_num, fac_num_neg;
    logic signed [7:0]     fac_range, fac_range_neg;
    logic [FAC_NUM_W-1:0]  fac_num_mag;
    logic [6:0]            fac_range_mag;
    logic [6:0]            fac_clip;
    logic signed [FREQ_W:0] span, span_neg;
    logic [FREQ_W-1:0]     span_mag;
    logic [FREQ_W-1:0]     frq_q, frq_off, freq_calc;

    srfg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srfg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (div_den),
        .rsp   (div_rsp),
        .quo   (div_quo)
    );

    // The input is free only between decisions.
    assign tick_stall  = (state_reg != S_IDLE);
    assign tick_accept = tick_valid && !tick_stall;

    assign result_valid       = result_valid_reg;
    assign requested_freq_khz = res_freq_reg;
    assign outcome            = res_outcome_reg;
    assign cycle_delta        = res_cd_reg;
    assign stall_delta        = res_sd_reg;

    // A negative elapsed time, read as signed, counts as too early.
    assign elapsed   = time_reg - last_update_time_reg;
    assign too_early = elapsed[TIME_W-1] ||
                       (elapsed < {{(TIME_W-DELAY_W){1'b0}}, cfg.update_delay});
    assign cyc_diff  = cyc_in_reg - cycle_baseline_reg;
    assign stl_diff  = stl_in_reg - stall_baseline_reg;

    // Stall percentage saturates at 300; anything above gives the same result.
    assign pct_sat = (div_rsp.ovf || (div_quo >= DIV_QUO_W'(PCT_CAP))) ?
                     PCT_CAP : div_quo[PCT_W-1:0];

    // Interpolation factor: 100 - (pct - low) * 100 / (high - low). Signs are
    // split off so the divider only sees magnitudes; quotients clamp to 0..100.
    assign pct_diff      = $signed({1'b0, pct_reg}) - $signed({3'b000, cfg.pct_low});
    assign fac_num       = $signed({{7{pct_diff[9]}}, pct_diff}) * 17'sd100;
    assign fac_num_neg   = -fac_num;
    assign fac_num_mag   = fac_num[16] ? fac_num_neg[FAC_NUM_W-1:0] : fac_num[FAC_NUM_W-1:0];
    assign fac_range     = $signed({1'b0, cfg.pct_high}) - $signed({1'b0, cfg.pct_low});
    assign fac_range_neg = -fac_range;
    assign fac_range_mag = fac_range[7] ? fac_range_neg[6:0] : fac_range[6:0];
    assign fac_clip      = neg_reg ? 7'd0 :
                           ((div_quo >= DIV_QUO_W'(FAC_FULL)) ? FAC_FULL : div_quo[6:0]);

    // Frequency: min + trunc(factor * (max - min) / 100), truncation toward zero.
    assign span      = $signed({1'b0, cfg.freq_max}) - $signed({1'b0, cfg.freq_min});
    assign span_neg  = -span;
    assign span_mag  = span[FREQ_W] ? span_neg[FREQ_W-1:0] : span[FREQ_W-1:0];
    assign frq_q     = div_quo[FREQ_W-1:0];
    assign frq_off   = neg_reg ? (~frq_q + FREQ_W'(1)) : frq_q;
    assign freq_calc = cfg.freq_min + frq_off;

    always_comb
    begin
        state_next            = state_reg;
        cycle_baseline_next   = cycle_baseline_reg;
        stall_baseline_next   = stall_baseline_reg;
        last_update_time_next = last_update_time_reg;
        prev_freq_next        = prev_freq_reg;
        result_valid_next     = result_valid_reg && result_stall;
        cd_next               = cd_reg;
        sd_next               = sd_reg;
        work_next             = work_reg;
        pct_next              = pct_reg;
        fac_next              = fac_reg;
        neg_next              = neg_reg;
        prod_next             = prod_reg;
        freq_next             = freq_reg;
        outcome_next          = outcome_reg;
        res_freq_next         = res_freq_reg;
        res_outcome_next      = res_outcome_reg;
        res_cd_next           = res_cd_reg;
        res_sd_next           = res_sd_reg;
        div_req.start         = 1'b0;
        div_req.nbits         = '0;
        div_num               = '0;
        div_den               = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_accept)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (!own_reg || too_early)
                begin
                    state_next = S_IDLE;
                end
                else if (!cyc_ok_reg)
                begin
                    freq_next    = cfg.freq_max;
                    outcome_next = OUTCOME_FAILED;
                    cd_next      = '0;
                    sd_next      = '0;
                    state_next   = S_EMIT;
                end
                else
                begin
                    cycle_baseline_next = cyc_in_reg;
                    if (!stl_ok_reg)
                    begin
                        freq_next    = cfg.freq_max;
                        outcome_next = OUTCOME_FAILED;
                        cd_next      = '0;
                        sd_next      = '0;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        stall_baseline_next = stl_in_reg;
                        cd_next             = cyc_diff;
                        sd_next             = stl_diff;
                        if (cyc_diff == '0)
                        begin
                            freq_next    = prev_freq_reg;
                            outcome_next = OUTCOME_KEPT;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_PCT_MUL;
                        end
                    end
                end
            end

            // 100 * s is built as (3 * s) << 5 plus s << 2, one add per cycle.
            S_PCT_MUL:
            begin
                work_next  = {6'd0, sd_reg, 1'b0} + {7'd0, sd_reg};
                state_next = S_PCT_LOAD;
            end

            S_PCT_LOAD:
            begin
                div_num       = {work_reg[DIV_NUM_W-6:0], 5'd0} + {5'd0, sd_reg, 2'd0};
                div_den       = cd_reg;
                div_req.start = 1'b1;
                div_req.nbits = DIV_CNT_W'(DIV_NUM_W);
                state_next    = S_PCT_DIV;
            end

            S_PCT_DIV:
            begin
                if (div_rsp.done)
                begin
                    pct_next   = pct_sat;
                    state_next = S_FAC_LOAD;
                end
            end

            S_FAC_LOAD:
            begin
                if (fac_range == 8'sd0)
                begin
                    // Equal bounds: a step at the bound instead of a ramp.
                    fac_next   = (pct_reg > {2'b00, cfg.pct_low}) ? 7'd0 : FAC_FULL;
                    state_next = S_FRQ_MUL;
                end
                else
                begin
                    div_num       = {fac_num_mag, {(DIV_NUM_W-FAC_NUM_W){1'b0}}};
                    div_den       = {{(DIV_DEN_W-7){1'b0}}, fac_range_mag};
                    div_req.start = 1'b1;
                    div_req.nbits = DIV_CNT_W'(FAC_NUM_W);
                    neg_next      = fac_num[16] ^ fac_range[7];
                    state_next    = S_FAC_DIV;
                end
            end

            S_FAC_DIV:
            begin
                if (div_rsp.done)
                begin
                    fac_next   = FAC_FULL - fac_clip;
                    state_next = S_FRQ_MUL;
                end
            end

            S_FRQ_MUL:
            begin
                prod_next  = FRQ_NUM_W'(fac_reg) * FRQ_NUM_W'(span_mag);
                neg_next   = span[FREQ_W];
                state_next = S_FRQ_LOAD;
            end

            S_FRQ_LOAD:
            begin
                div_num       = {prod_reg, {(DIV_NUM_W-FRQ_NUM_W){1'b0}}};
                div_den       = DIV_DEN_W'(FRQ_DIVISOR);
                div_req.start = 1'b1;
                div_req.nbits = DIV_CNT_W'(FRQ_NUM_W);
                state_next    = S_FRQ_DIV;
            end

            S_FRQ_DIV:
            begin
                if (div_rsp.done)
                begin
                    freq_next    = freq_calc;
                    outcome_next = OUTCOME_COMPUTED;
                    state_next   = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next     = 1'b1;
                    res_freq_next         = freq_reg;
                    res_outcome_next      = outcome_reg;
                    res_cd_next           = cd_reg;
                    res_sd_next           = sd_reg;
                    prev_freq_next        = freq_reg;
                    last_update_time_next = time_reg;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            cycle_baseline_reg   <= '0;
            stall_baseline_reg   <= '0;
            last_update_time_reg <= '0;
            prev_freq_reg        <= RST_FREQ_MAX;
            result_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            cycle_baseline_reg   <= cycle_baseline_next;
            stall_baseline_reg   <= stall_baseline_next;
            last_update_time_reg <= last_update_time_next;
            prev_freq_reg        <= prev_freq_next;
            result_valid_reg     <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            time_reg   <= time_ns;
            own_reg    <= on_own_cpu;
            cyc_ok_reg <= cycles_ok;
            cyc_in_reg <= cycles_total;
            stl_ok_reg <= stalls_ok;
            stl_in_reg <= stalls_total;
        end
        cd_reg          <= cd_next;
        sd_reg          <= sd_next;
        work_reg        <= work_next;
        pct_reg         <= pct_next;
        fac_reg         <= fac_next;
        neg_reg         <= neg_next;
        prod_reg        <= prod_next;
        freq_reg        <= freq_next;
        outcome_reg     <= outcome_next;
        res_freq_reg    <= res_freq_next;
        res_outcome_reg <= res_outcome_next;
        res_cd_reg      <= res_cd_next;
        res_sd_reg      <= res_sd_next;
    end

    a_baseline_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        (cycle_baseline_reg != $past(cycle_baseline_reg)) |-> $past(state_reg == S_CHECK))
        else $error("cycle baseline moved outside the tick check");

    a_update_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (last_update_time_reg != $past(last_update_time_reg)) |-> result_valid_reg)
        else $error("last update time moved without a result word");

    a_div_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (state_reg == S_PCT_LOAD || state_reg == S_FAC_LOAD ||
                           state_reg == S_FRQ_LOAD))
        else $error("divider started outside a load step");

endmodule
